[sv/rc_stick_calibrate_and_scale_unit_defines.svh]
// ---------------------------------------------------------------------------
// rc stick calibrate and scale unit: assertion macros
// shared concurrent assertion forms, clocked on clk_i and idle in reset
// ---------------------------------------------------------------------------
`ifndef RC_STICK_CALIBRATE_AND_SCALE_UNIT_DEFINES_SVH
`define RC_STICK_CALIBRATE_AND_SCALE_UNIT_DEFINES_SVH

// property must hold at every edge outside reset
`define RCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define RCS_ASSERT_NEVER(lbl, cond, msg) \
  `RCS_ASSERT(lbl, !(cond), msg)

`endif

[sv/rcs_pkg.sv]
// ---------------------------------------------------------------------------
// rcs_pkg
// types, constants and helpers shared by the stick calibrate and scale unit
// ---------------------------------------------------------------------------
package rcs_pkg;

  localparam int unsigned RAW_BITS    = 11;
  localparam int unsigned BOUND_W     = 11;
  localparam int unsigned RAW_EXT_W   = (RAW_BITS > BOUND_W) ? RAW_BITS : BOUND_W;
  localparam int unsigned OUT_W       = 10;
  localparam int unsigned DZ_W        = 9;
  localparam int unsigned NUM_AXES    = 5;
  localparam int unsigned NUM_CENTRED = 3;
  localparam int unsigned AXIS_W      = 3;
  localparam int unsigned QUOT_W      = 10;
  localparam int unsigned NUM_W       = BOUND_W + QUOT_W;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned SEG_W       = BOUND_W + 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 9;

  typedef logic [BOUND_W-1:0] bound_t;
  typedef bound_t [NUM_AXES-1:0] axis_vec_t;

  localparam bound_t RAW_SAT     = BOUND_W'(2047);
  localparam bound_t BOUND_RESET = BOUND_W'(1500);
  localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(20);

  localparam logic [OUT_W-1:0] OUT_MID          = OUT_W'(500);
  localparam logic [OUT_W-1:0] OUT_SEG_LO_END   = OUT_W'(499);
  localparam logic [OUT_W-1:0] OUT_SEG_HI_START = OUT_W'(501);
  localparam logic [OUT_W-1:0] OUT_FULL         = OUT_W'(1000);
  localparam logic [OUT_W-1:0] OUT_ZERO         = OUT_W'(0);

  localparam logic [QUOT_W-1:0] GAIN_CENTRED = QUOT_W'(499);
  localparam logic [QUOT_W-1:0] GAIN_LINEAR  = QUOT_W'(1000);

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE = 1'b0,
    CFG_CAL_EN   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUNDS,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                action;
    logic [RAW_BITS-1:0] roll_raw;
    logic [RAW_BITS-1:0] pitch_raw;
    logic [RAW_BITS-1:0] yaw_raw;
    logic [RAW_BITS-1:0] throttle_raw;
    logic [RAW_BITS-1:0] aux_raw;
    logic                link_up;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] roll_scaled;
    logic [OUT_W-1:0] pitch_scaled;
    logic [OUT_W-1:0] yaw_scaled;
    logic [OUT_W-1:0] throttle_scaled;
    logic [OUT_W-1:0] aux_scaled;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic widen;
    logic rotate;
  } store_ctrl_t;

  // value is the whole result for a constant answer, the offset otherwise
  typedef struct packed {
    logic             is_div;
    logic [OUT_W-1:0] value;
    bound_t           diff;
    bound_t           den;
    logic             centred;
  } prep_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic bound_t sat_raw(input logic [RAW_BITS-1:0] r);
    logic [RAW_EXT_W-1:0] r_ext;
    r_ext = RAW_EXT_W'(r);
    if (r_ext > RAW_EXT_W'(RAW_SAT)) begin
      return RAW_SAT;
    end
    return BOUND_W'(r_ext);
  endfunction

endpackage

[sv/rcs_bound_store.sv]
// ---------------------------------------------------------------------------
// rcs_bound_store
// per-axis raw sample and calibration bounds, rotated one axis per step
// ---------------------------------------------------------------------------
module rcs_bound_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcs_pkg::store_ctrl_t ctrl_i,
  input  rcs_pkg::axis_vec_t  raw_i,
  output rcs_pkg::bound_t     raw_o,
  output rcs_pkg::bound_t     lo_o,
  output rcs_pkg::bound_t     hi_o
);

  rcs_pkg::axis_vec_t raw_q;
  rcs_pkg::axis_vec_t lo_q;
  rcs_pkg::axis_vec_t hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= {rcs_pkg::NUM_AXES{rcs_pkg::BOUND_RESET}};
      hi_q <= {rcs_pkg::NUM_AXES{rcs_pkg::BOUND_RESET}};
    end else if (ctrl_i.clear) begin
      lo_q <= {rcs_pkg::NUM_AXES{rcs_pkg::BOUND_RESET}};
      hi_q <= {rcs_pkg::NUM_AXES{rcs_pkg::BOUND_RESET}};
    end else if (ctrl_i.widen) begin
      for (int i = 0; i < rcs_pkg::NUM_AXES; i++) begin
        if (raw_q[i] < lo_q[i]) begin
          lo_q[i] <= raw_q[i];
        end
        if (raw_q[i] > hi_q[i]) begin
          hi_q[i] <= raw_q[i];
        end
      end
    end else if (ctrl_i.rotate) begin
      // head moves on to the next axis, five turns bring the order back
      lo_q <= {lo_q[0], lo_q[rcs_pkg::NUM_AXES-1:1]};
      hi_q <= {hi_q[0], hi_q[rcs_pkg::NUM_AXES-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      raw_q <= raw_i;
    end else if (ctrl_i.rotate) begin
      raw_q <= {raw_q[0], raw_q[rcs_pkg::NUM_AXES-1:1]};
    end
  end

  assign raw_o = raw_q[0];
  assign lo_o  = lo_q[0];
  assign hi_o  = hi_q[0];

endmodule

[sv/rcs_axis_prep.sv]
// ---------------------------------------------------------------------------
// rcs_axis_prep
// clamps one axis and picks its segment: constant answer or divide operands
// ---------------------------------------------------------------------------
module rcs_axis_prep (
  input  rcs_pkg::bound_t             raw_i,
  input  rcs_pkg::bound_t             lo_i,
  input  rcs_pkg::bound_t             hi_i,
  input  logic [rcs_pkg::DZ_W-1:0]    dz_i,
  input  logic                        centred_i,
  output rcs_pkg::prep_t              prep_o
);

  logic                                collapsed;
  rcs_pkg::bound_t                     r;
  rcs_pkg::bound_t                     mid;
  logic [rcs_pkg::BOUND_W:0]           sum;
  logic signed [rcs_pkg::SEG_W-1:0]    r_s;
  logic signed [rcs_pkg::SEG_W-1:0]    lo_s;
  logic signed [rcs_pkg::SEG_W-1:0]    hi_s;
  logic signed [rcs_pkg::SEG_W-1:0]    mid_s;
  logic signed [rcs_pkg::SEG_W-1:0]    dz_s;
  logic signed [rcs_pkg::SEG_W-1:0]    lo_dz;
  logic signed [rcs_pkg::SEG_W-1:0]    hi_dz;
  logic signed [rcs_pkg::SEG_W-1:0]    seg_den;
  logic signed [rcs_pkg::SEG_W-1:0]    seg_diff;

  always_comb begin
    collapsed = (hi_i <= lo_i);
    if (raw_i < lo_i) begin
      r = lo_i;
    end else if (raw_i > hi_i) begin
      r = hi_i;
    end else begin
      r = raw_i;
    end
    sum   = {1'b0, lo_i} + {1'b0, hi_i};
    mid   = sum[rcs_pkg::BOUND_W:1];
    r_s   = signed'(rcs_pkg::SEG_W'(r));
    lo_s  = signed'(rcs_pkg::SEG_W'(lo_i));
    hi_s  = signed'(rcs_pkg::SEG_W'(hi_i));
    mid_s = signed'(rcs_pkg::SEG_W'(mid));
    dz_s  = signed'(rcs_pkg::SEG_W'(dz_i));
    // a wide deadzone can push the lower edge below zero
    lo_dz = mid_s - dz_s;
    hi_dz = mid_s + dz_s;

    seg_den  = '0;
    seg_diff = '0;
    prep_o.is_div  = 1'b0;
    prep_o.value   = rcs_pkg::OUT_ZERO;
    prep_o.diff    = '0;
    prep_o.den     = '0;
    prep_o.centred = centred_i;

    if (!centred_i) begin
      if (!collapsed) begin
        prep_o.is_div = 1'b1;
        prep_o.diff   = r - lo_i;
        prep_o.den    = hi_i - lo_i;
      end
    end else if (collapsed) begin
      prep_o.value = rcs_pkg::OUT_MID;
    end else if (r_s >= lo_dz && r_s <= hi_dz) begin
      prep_o.value = rcs_pkg::OUT_MID;
    end else if (r < mid) begin
      if (lo_dz <= lo_s) begin
        prep_o.value = rcs_pkg::OUT_SEG_LO_END;
      end else begin
        seg_den       = lo_dz - lo_s;
        prep_o.is_div = 1'b1;
        prep_o.diff   = r - lo_i;
        prep_o.den    = seg_den[rcs_pkg::BOUND_W-1:0];
      end
    end else begin
      if (hi_s <= hi_dz) begin
        prep_o.value = rcs_pkg::OUT_FULL;
      end else begin
        seg_den       = hi_s - hi_dz;
        seg_diff      = r_s - hi_dz;
        prep_o.is_div = 1'b1;
        prep_o.value  = rcs_pkg::OUT_SEG_HI_START;
        prep_o.diff   = seg_diff[rcs_pkg::BOUND_W-1:0];
        prep_o.den    = seg_den[rcs_pkg::BOUND_W-1:0];
      end
    end
  end

endmodule

[sv/rcs_serial_div.sv]
// ---------------------------------------------------------------------------
// rcs_serial_div
// restoring divider, one quotient bit per cycle, quotient below 1024
// ---------------------------------------------------------------------------
`include "rc_stick_calibrate_and_scale_unit_defines.svh"

module rcs_serial_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rcs_pkg::NUM_W-1:0]    num_i,
  input  rcs_pkg::bound_t              den_i,
  output rcs_pkg::div_stat_t           stat_o,
  output logic [rcs_pkg::QUOT_W-1:0]   quot_o
);

  rcs_pkg::bound_t                   den_q;
  rcs_pkg::bound_t                   rem_q;
  // numerator bits leave at the top while quotient bits enter at the bottom
  logic [rcs_pkg::QUOT_W-1:0]        shift_q;
  logic [rcs_pkg::STEP_W-1:0]        step_q;
  logic                              busy_q;
  logic                              done_q;
  logic [rcs_pkg::BOUND_W:0]         trial;
  logic [rcs_pkg::BOUND_W:0]         trial_sub;
  logic                              take;

  always_comb begin
    trial     = {rem_q, shift_q[rcs_pkg::QUOT_W-1]};
    trial_sub = trial - {1'b0, den_q};
    take      = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= rcs_pkg::STEP_W'(rcs_pkg::QUOT_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= num_i[rcs_pkg::NUM_W-1:rcs_pkg::QUOT_W];
      shift_q <= num_i[rcs_pkg::QUOT_W-1:0];
      den_q   <= den_i;
    end else if (busy_q) begin
      rem_q   <= take ? trial_sub[rcs_pkg::BOUND_W-1:0] : trial[rcs_pkg::BOUND_W-1:0];
      shift_q <= {shift_q[rcs_pkg::QUOT_W-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = shift_q;

  `RCS_ASSERT_NEVER(a_div_restart, start_i && busy_q, "divider restarted while busy")
  `RCS_ASSERT(a_div_rem_bound, busy_q |-> (rem_q < den_q), "partial remainder not below divisor")
  `RCS_ASSERT(a_div_quot_range, done_q |-> (shift_q <= rcs_pkg::OUT_FULL), "quotient above full scale")

endmodule

[sv/rc_stick_calibrate_and_scale_unit.sv]
// ---------------------------------------------------------------------------
// rc_stick_calibrate_and_scale_unit
// five-axis stick calibration with deadzone and linear scaling to 0..1000
// ---------------------------------------------------------------------------
// One transfer in gives one transfer out. An item is taken only while the unit
// is idle and occupies it until it can take the next: a bounds step that clears
// them or, with calibration on, widens them, then per axis either a constant
// answer from segment selection or, for an axis that needs a division, segment
// selection, multiply by the gain and the bit-serial divider, and finally
// loading the output register before it returns to idle.
// The single shared restoring divider, one quotient bit per cycle, sets the
// worst case. The finished result sits in an output register, so a stalled
// consumer only holds the unit once the next result is ready. Bounds reset to
// 1500 with no clearing pass; configuration writes take effect at once.
// ---------------------------------------------------------------------------
`include "rc_stick_calibrate_and_scale_unit_defines.svh"

module rc_stick_calibrate_and_scale_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rcs_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rcs_pkg::out_item_t                out_data_o
);

  logic [rcs_pkg::DZ_W-1:0]    dz_q;
  logic                        cal_en_q;
  rcs_pkg::state_e             state_q;
  rcs_pkg::state_e             state_d;
  logic [rcs_pkg::AXIS_W-1:0]  axis_q;
  logic                        action_q;
  logic                        link_q;
  rcs_pkg::prep_t              prep_q;
  logic [rcs_pkg::OUT_W-1:0]   res_q [rcs_pkg::NUM_AXES];
  rcs_pkg::out_item_t          out_q;
  logic                        out_valid_q;

  logic                        accept;
  logic                        last_axis;
  logic                        centred;
  logic                        axis_done;
  logic                        out_load;
  logic                        div_start;
  logic [rcs_pkg::OUT_W-1:0]   res_value;
  logic [rcs_pkg::QUOT_W-1:0]  gain;
  logic [rcs_pkg::NUM_W-1:0]   num;
  logic [rcs_pkg::QUOT_W-1:0]  quot;
  rcs_pkg::axis_vec_t          raw_vec;
  rcs_pkg::store_ctrl_t        store_ctrl;
  rcs_pkg::bound_t             head_raw;
  rcs_pkg::bound_t             head_lo;
  rcs_pkg::bound_t             head_hi;
  rcs_pkg::prep_t              prep;
  rcs_pkg::div_stat_t          div_stat;
  logic                        in_div;
  logic                        in_done;
  logic                        out_in_range;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q     <= rcs_pkg::DZ_RESET;
      cal_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (rcs_pkg::cfg_reg_e'(cfg_idx_i))
        rcs_pkg::CFG_DEADZONE: begin
          dz_q <= cfg_wdata_i[rcs_pkg::DZ_W-1:0];
        end
        rcs_pkg::CFG_CAL_EN: begin
          cal_en_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == rcs_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_axis  = (axis_q == rcs_pkg::AXIS_LAST);
  assign centred    = (axis_q < rcs_pkg::AXIS_W'(rcs_pkg::NUM_CENTRED));

  always_comb begin
    raw_vec[0] = rcs_pkg::sat_raw(in_data_i.roll_raw);
    raw_vec[1] = rcs_pkg::sat_raw(in_data_i.pitch_raw);
    raw_vec[2] = rcs_pkg::sat_raw(in_data_i.yaw_raw);
    raw_vec[3] = rcs_pkg::sat_raw(in_data_i.throttle_raw);
    raw_vec[4] = rcs_pkg::sat_raw(in_data_i.aux_raw);
  end

  rcs_bound_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (store_ctrl),
    .raw_i  (raw_vec),
    .raw_o  (head_raw),
    .lo_o   (head_lo),
    .hi_o   (head_hi)
  );

  rcs_axis_prep u_prep (
    .raw_i     (head_raw),
    .lo_i      (head_lo),
    .hi_i      (head_hi),
    .dz_i      (dz_q),
    .centred_i (centred),
    .prep_o    (prep)
  );

  assign gain = prep_q.centred ? rcs_pkg::GAIN_CENTRED : rcs_pkg::GAIN_LINEAR;
  assign num  = rcs_pkg::NUM_W'(prep_q.diff) * rcs_pkg::NUM_W'(gain);

  rcs_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (prep_q.den),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = rcs_pkg::ST_BOUNDS;
        end
      end
      rcs_pkg::ST_BOUNDS: begin
        state_d = rcs_pkg::ST_PREP;
      end
      rcs_pkg::ST_PREP: begin
        if (prep.is_div) begin
          state_d = rcs_pkg::ST_MUL;
        end else if (last_axis) begin
          state_d = rcs_pkg::ST_DONE;
        end
      end
      rcs_pkg::ST_MUL: begin
        state_d = rcs_pkg::ST_DIV;
      end
      rcs_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = last_axis ? rcs_pkg::ST_DONE : rcs_pkg::ST_PREP;
        end
      end
      rcs_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = rcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rcs_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    store_ctrl.load   = accept;
    store_ctrl.clear  = 1'b0;
    store_ctrl.widen  = 1'b0;
    axis_done         = 1'b0;
    div_start         = 1'b0;
    out_load          = 1'b0;
    res_value         = prep.value;
    case (state_q)
      rcs_pkg::ST_BOUNDS: begin
        store_ctrl.clear = action_q;
        store_ctrl.widen = !action_q && cal_en_q;
      end
      rcs_pkg::ST_PREP: begin
        axis_done = !prep.is_div;
      end
      rcs_pkg::ST_MUL: begin
        div_start = 1'b1;
      end
      rcs_pkg::ST_DIV: begin
        axis_done = div_stat.done;
        res_value = prep_q.value + quot;
      end
      rcs_pkg::ST_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
    store_ctrl.rotate = axis_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcs_pkg::ST_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rcs_pkg::ST_BOUNDS) begin
        axis_q <= '0;
      end else if (axis_done) begin
        axis_q <= axis_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= in_data_i.action;
      link_q   <= in_data_i.link_up;
    end
    if (state_q == rcs_pkg::ST_PREP) begin
      prep_q <= prep;
    end
    // results enter at the tail, roll ends up at the head
    if (axis_done) begin
      for (int i = 0; i < rcs_pkg::NUM_AXES - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
      res_q[rcs_pkg::NUM_AXES-1] <= res_value;
    end
    if (out_load) begin
      out_q.roll_scaled     <= res_q[0];
      out_q.pitch_scaled    <= res_q[1];
      out_q.yaw_scaled      <= res_q[2];
      out_q.throttle_scaled <= link_q ? res_q[3] : rcs_pkg::OUT_ZERO;
      out_q.aux_scaled      <= res_q[4];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_div       = (state_q == rcs_pkg::ST_DIV);
  assign in_done      = (state_q == rcs_pkg::ST_DONE);
  assign out_in_range = (out_q.roll_scaled <= rcs_pkg::OUT_FULL) &&
                        (out_q.pitch_scaled <= rcs_pkg::OUT_FULL) &&
                        (out_q.yaw_scaled <= rcs_pkg::OUT_FULL) &&
                        (out_q.throttle_scaled <= rcs_pkg::OUT_FULL) &&
                        (out_q.aux_scaled <= rcs_pkg::OUT_FULL);

  `RCS_ASSERT(a_out_range, out_valid_o |-> out_in_range, "scaled output above full scale")
  `RCS_ASSERT(a_div_tracks_state, in_div |-> (|div_stat), "waiting on an idle divider")
  `RCS_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(in_done), "result before last axis")

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: stick calibrate and scale unit testbench
// drives stick frames through the input channel in random bursts, predicts
// each scaled result from its own copy of the bounds and settings, and checks
// every output transfer against it while the output side stalls at random
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import rcs_pkg::*;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;
  localparam int   RAW_MAX    = 2047;
  localparam int   SETTLE_CYCLES  = 80;
  localparam int   WATCHDOG_LIMIT = 5000;
  localparam int   NUM_PHASES     = 8;
  localparam int   PHASE_FRAMES   = 70;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  rc_stick_calibrate_and_scale_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predictor state
  int cal_low [NUM_AXES];
  int cal_high [NUM_AXES];
  int dz_setting = int'(DZ_RESET);
  int cal_enable = 0;

  in_item_t  frames_to_send [$];
  out_item_t expected_sticks [$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  logic      in_fire = 1'b0;

  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  string axis_name [NUM_AXES] = '{"roll", "pitch", "yaw", "throttle", "aux"};
  int    dz_plan [NUM_PHASES] = '{20, 0, 500, 137, 0, 500, 333, 20};
  int    cal_plan [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 1};

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int map_segment(input int x, input int lo, input int hi,
                                     input int out_lo, input int out_hi);
    if (hi <= lo) begin
      return out_hi;
    end
    return out_lo + (x - lo) * (out_hi - out_lo) / (hi - lo);
  endfunction

  function automatic int centred_value(input int r, input int mn, input int mx);
    int mid;
    int x;
    if (mx <= mn) begin
      return int'(OUT_MID);
    end
    mid = (mn + mx) / 2;
    x = (r < mn) ? mn : ((r > mx) ? mx : r);
    // signed compares: a wide deadzone swallows the whole range
    if (x >= mid - dz_setting && x <= mid + dz_setting) begin
      return int'(OUT_MID);
    end
    if (x < mid) begin
      return map_segment(x, mn, mid - dz_setting, 0, int'(OUT_SEG_LO_END));
    end
    return map_segment(x, mid + dz_setting, mx, int'(OUT_SEG_HI_START), int'(OUT_FULL));
  endfunction

  function automatic int linear_value(input int r, input int mn, input int mx);
    int x;
    if (mx <= mn) begin
      return 0;
    end
    x = (r < mn) ? mn : ((r > mx) ? mx : r);
    return map_segment(x, mn, mx, 0, int'(OUT_FULL));
  endfunction

  function automatic void reset_bounds();
    for (int i = 0; i < NUM_AXES; i++) begin
      cal_low[i] = int'(BOUND_RESET);
      cal_high[i] = int'(BOUND_RESET);
    end
  endfunction

  function automatic out_item_t scale_stick_frame(input in_item_t frame);
    int        raw [NUM_AXES];
    int        res [NUM_AXES];
    out_item_t o;
    if (frame.action == ACT_CLEAR) begin
      reset_bounds();
      o.roll_scaled = OUT_MID;
      o.pitch_scaled = OUT_MID;
      o.yaw_scaled = OUT_MID;
      o.throttle_scaled = OUT_ZERO;
      o.aux_scaled = OUT_ZERO;
      return o;
    end
    raw[0] = int'(frame.roll_raw);
    raw[1] = int'(frame.pitch_raw);
    raw[2] = int'(frame.yaw_raw);
    raw[3] = int'(frame.throttle_raw);
    raw[4] = int'(frame.aux_raw);
    for (int i = 0; i < NUM_AXES; i++) begin
      if (raw[i] > int'(RAW_SAT)) begin
        raw[i] = int'(RAW_SAT);
      end
      if (cal_enable != 0) begin
        if (raw[i] < cal_low[i]) begin
          cal_low[i] = raw[i];
        end
        if (raw[i] > cal_high[i]) begin
          cal_high[i] = raw[i];
        end
      end
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      if (i < NUM_CENTRED) begin
        res[i] = centred_value(raw[i], cal_low[i], cal_high[i]);
      end else begin
        res[i] = linear_value(raw[i], cal_low[i], cal_high[i]);
      end
    end
    if (!frame.link_up) begin
      res[3] = 0;
    end
    o.roll_scaled = OUT_W'(res[0]);
    o.pitch_scaled = OUT_W'(res[1]);
    o.yaw_scaled = OUT_W'(res[2]);
    o.throttle_scaled = OUT_W'(res[3]);
    o.aux_scaled = OUT_W'(res[4]);
    return o;
  endfunction

  function automatic in_item_t make_frame(input logic act, input int r, input int p,
                                          input int y, input int t, input int a,
                                          input logic link);
    in_item_t f;
    f.action = act;
    f.roll_raw = RAW_BITS'(r);
    f.pitch_raw = RAW_BITS'(p);
    f.yaw_raw = RAW_BITS'(y);
    f.throttle_raw = RAW_BITS'(t);
    f.aux_raw = RAW_BITS'(a);
    f.link_up = link;
    return f;
  endfunction

  function automatic int random_raw();
    case ($urandom_range(0, 7))
      0, 1: return $urandom_range(0, RAW_MAX);
      2: return ($urandom_range(0, 1) != 0) ? RAW_MAX : 0;
      3: return ($urandom_range(0, 1) != 0) ? $urandom_range(RAW_MAX - 15, RAW_MAX)
                                           : $urandom_range(0, 15);
      default: return $urandom_range(1000, 2000);
    endcase
  endfunction

  function automatic in_item_t random_frame();
    logic act;
    act = ($urandom_range(0, 29) == 0) ? ACT_CLEAR : ACT_SAMPLE;
    return make_frame(act, random_raw(), random_raw(), random_raw(), random_raw(),
                      random_raw(), ($urandom_range(0, 5) != 0));
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    if (idx == CFG_DEADZONE) begin
      dz_setting = value & 'h1ff;
    end else begin
      cal_enable = value & 1;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frames_to_send.size() != 0 || in_valid_i || expected_sticks.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apply_setting(input int dz, input int cal);
    wait_drained();
    // every accepted frame has already been answered before the settle wait
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_CAL_EN, cal);
  endtask

  // sender: bursts of random length, random gaps in between
  always @(negedge clk_i) begin : drive_frames
    logic     next_valid;
    in_item_t next_data;
    next_valid = in_valid_i;
    next_data = in_data_i;
    if (!in_valid_i || in_fire) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (frames_to_send.size() > 0) begin
        next_data = frames_to_send.pop_front();
        next_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 60);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left = $urandom_range(1, 20);
        end
      end
    end
    in_valid_i <= next_valid;
    in_data_i <= next_data;
  end

  // receiver: stretches of always ready, coin-flip stalls and heavy stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) != 0);
      default: out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    out_item_t                  want;
    logic [$bits(out_item_t)-1:0] got_bits;
    logic [$bits(out_item_t)-1:0] want_bits;
    if (!rst_ni) begin
      in_fire <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_sticks.push_back(scale_stick_frame(in_data_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_sticks.size() == 0) begin
          report_mismatch($sformatf("result %h with none outstanding", out_data_o));
        end else begin
          want = expected_sticks.pop_front();
          got_bits = out_data_o;
          want_bits = want;
          for (int i = 0; i < NUM_AXES; i++) begin
            if (got_bits[(NUM_AXES-1-i)*OUT_W +: OUT_W]
                !== want_bits[(NUM_AXES-1-i)*OUT_W +: OUT_W]) begin
              report_mismatch($sformatf("%s_scaled got %0d want %0d", axis_name[i],
                              got_bits[(NUM_AXES-1-i)*OUT_W +: OUT_W],
                              want_bits[(NUM_AXES-1-i)*OUT_W +: OUT_W]));
            end
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    reset_bounds();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: bounds collapsed, nothing learnt
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 0, 0, 0, 0, 0, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX,
                                        RAW_MAX, 1'b0));
    frames_to_send.push_back(make_frame(ACT_CLEAR, 1234, 77, RAW_MAX, 0, 999, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1500, 1500, 1500, 1500, 1500, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1234, 567, RAW_MAX, 0, 1999, 1'b1));

    // learning: widen to full range, probe deadzone edges around mid 1023
    apply_setting(20, 1);
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1500, 1500, 1500, 1500, 1500, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 0, 0, 0, 0, 0, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX,
                                        RAW_MAX, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1023, 1023, 1023, 1023, 1023, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1003, 1043, 1004, 1042, 1024, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1002, 1044, 1002, 1044, 1044, 1'b0));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1, 2046, 0, RAW_MAX, 0, 1'b0));
    frames_to_send.push_back(make_frame(ACT_CLEAR, 0, 0, 0, 0, 0, 1'b0));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1400, 1600, 1490, 1510, 1500, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1450, 1550, 1495, 1505, 1700, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1499, 1501, 1500, 1500, 1499, 1'b1));

    // deadzone wider than half the range
    apply_setting(500, 1);
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 0, RAW_MAX, 1023, 500, 1500, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1, 2046, 300, 1800, 20, 1'b1));

    // no deadzone, bounds frozen
    apply_setting(0, 0);
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 1023, 1024, 1022, 1023, 1024, 1'b1));
    frames_to_send.push_back(make_frame(ACT_SAMPLE, 0, RAW_MAX, 1, 2046, 1, 1'b0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_setting(dz_plan[ph], cal_plan[ph]);
      repeat (PHASE_FRAMES) frames_to_send.push_back(random_frame());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
